// ===== rtl/lcsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsr_pkg
// Shared constants, types and register indexes of the load cell reader.
// ----------------------------------------------------------------------------
package lcsr_pkg;

  localparam int DATA_BITS = 24;
  localparam int FRAC_BITS = 8;
  localparam int WEIGHT_W  = 32;
  localparam int HALF_W    = 16;
  localparam int GAP_W     = 24;
  localparam int CFG_W     = (GAP_W > HALF_W) ? GAP_W : HALF_W;
  localparam int CFG_IDX_W = 1;

  // numerator (raw - tare) << (FRAC_BITS + 1); quotient keeps one bit above
  // the weight so that overflow can be seen
  localparam int NUM_W = DATA_BITS + FRAC_BITS + 1;
  localparam int QUO_W = (NUM_W > WEIGHT_W) ? NUM_W : WEIGHT_W + 1;
  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam int BIT_W = $clog2(DATA_BITS + 1);

  localparam logic [HALF_W-1:0]    HALF_RESET = HALF_W'(168);
  localparam logic [GAP_W-1:0]     GAP_RESET  = GAP_W'(21001);
  localparam logic [DATA_BITS-1:0] RAW_FLIP   = {1'b1, {(DATA_BITS-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAP_X2      = CFG_IDX_W'(1);

  typedef enum logic [4:0] {
    PH_SETTLE = 5'b00001,
    PH_WAIT   = 5'b00010,
    PH_HIGH   = 5'b00100,
    PH_LOW    = 5'b01000,
    PH_GAIN   = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_FIN  = 3'b100
  } div_state_t;

  typedef struct packed {
    logic                 sck;
    logic                 sck_next;
    logic                 complete;
    logic                 captured;
    logic [DATA_BITS-1:0] raw;
    logic [DATA_BITS-1:0] tare;
  } lcsr_seq_t;

  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] weight;
  } lcsr_div_t;

endpackage

// ===== rtl/lcsr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsr_if
// Handshake channels: per-tick pin samples in, per-tick pin/sample results out.
// ----------------------------------------------------------------------------
interface lcsr_in_if;
  logic valid;
  logic ready;
  logic dout_level;
  logic tare_request;

  modport source (output valid, output dout_level, output tare_request, input ready);
  modport sink (input valid, input dout_level, input tare_request, output ready);
endinterface

interface lcsr_out_if import lcsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 sck_level;
  logic                 sample_valid;
  logic [DATA_BITS-1:0] raw_code;
  logic [WEIGHT_W-1:0]  weight_q8;

  modport source (output valid, output sck_level, output sample_valid,
                  output raw_code, output weight_q8, input ready);
  modport sink (input valid, input sck_level, input sample_valid,
                input raw_code, input weight_q8, output ready);
endinterface

// ===== rtl/load_cell_serial_reader_tare_scale_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_serial_reader_tare_scale_core
// One-channel bridge converter reader (gain 128) with tare capture and
// fixed-point scaling of the net weight.
// ----------------------------------------------------------------------------
// Channel   Dir   Payload                                         Width
// tick      in    dout_level, tare_request                        1, 1
// result    out   sck_level, sample_valid, raw_code, weight_q8    1, 1, 24, 32
// cfg_*     in    cfg_index 0 half_period_ticks, 1 gap_x2         16, 24
//
// An ordinary tick is registered straight into the output register; that
// register is freed in the cycle its transaction is taken, so ticks can follow with no gap.
// The tick that completes a sample holds the input off until the restoring
// divider, one quotient bit per cycle, has finished.
// Reset clears state to the settle phase, tare and the result valid to zero and
// the registers to 168 and 21001. A stalled result holds the input off.
// ----------------------------------------------------------------------------
module load_cell_serial_reader_tare_scale_core import lcsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  lcsr_in_if.sink              tick,
  lcsr_out_if.source           result
);

  logic [HALF_W-1:0]    half_period_ticks;
  logic [GAP_W-1:0]     gap_x2;
  logic                 accept;
  logic                 wait_div;
  logic                 out_valid;
  logic                 out_sck;
  logic                 out_sample;
  logic [DATA_BITS-1:0] out_raw;
  logic [WEIGHT_W-1:0]  out_weight;
  lcsr_seq_t            seq;
  lcsr_div_t            div;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_RESET;
      gap_x2            <= GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: half_period_ticks <= cfg_data[HALF_W-1:0];
        REG_GAP_X2:      gap_x2            <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick.ready = !wait_div && (!out_valid || result.ready);
  assign accept     = tick.valid && tick.ready;

  lcsr_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .step              (accept),
    .dout_level        (tick.dout_level),
    .tare_request      (tick.tare_request),
    .half_period_ticks (half_period_ticks),
    .status            (seq)
  );

  lcsr_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (seq.captured),
    .raw    (seq.raw),
    .tare   (seq.tare),
    .gap_x2 (gap_x2),
    .status (div)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      wait_div  <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (accept && !seq.complete) begin
        out_valid  <= 1'b1;
        out_sck    <= seq.sck_next;
        out_sample <= 1'b0;
        out_raw    <= seq.raw;
        out_weight <= div.weight;
      end
      if (accept && seq.complete) begin
        wait_div <= 1'b1;
      end
      if (div.done) begin
        wait_div   <= 1'b0;
        out_valid  <= 1'b1;
        out_sck    <= seq.sck;
        out_sample <= 1'b1;
        out_raw    <= seq.raw;
        out_weight <= div.weight;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.sck_level    = out_sck;
  assign result.sample_valid = out_sample;
  assign result.raw_code     = out_raw;
  assign result.weight_q8    = out_weight;

endmodule

// ===== rtl/lcsr_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsr_seq
// Serial clock sequencer: settle, ready wait, data pulses shifting the pin
// in MSB first, gain pulse, then sample and tare capture.
// ----------------------------------------------------------------------------
module lcsr_seq import lcsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              dout_level,
  input  logic              tare_request,
  input  logic [HALF_W-1:0] half_period_ticks,
  output lcsr_seq_t         status
);

  phase_t               phase, phase_next;
  logic [HALF_W-1:0]    tick_count, tick_count_next;
  logic [BIT_W-1:0]     bit_count, bit_count_next;
  logic [DATA_BITS-1:0] shift_data, shift_data_next;
  logic [DATA_BITS-1:0] tare_value, tare_value_next;
  logic [DATA_BITS-1:0] last_raw, last_raw_next;
  logic                 tare_pending, tare_pending_next;
  logic                 sck_reg, sck_reg_next;
  logic                 captured;
  logic                 complete;
  logic [HALF_W-1:0]    hp;
  logic [HALF_W-1:0]    tick_inc;
  logic                 half_done;
  logic                 pend_eff;

  assign hp        = (half_period_ticks == '0) ? HALF_W'(1) : half_period_ticks;
  assign tick_inc  = tick_count + HALF_W'(1);
  assign half_done = (tick_inc >= hp);
  assign pend_eff  = tare_pending | tare_request;

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_count_next    = bit_count;
    shift_data_next   = shift_data;
    tare_value_next   = tare_value;
    last_raw_next     = last_raw;
    tare_pending_next = pend_eff;
    sck_reg_next      = sck_reg;
    complete          = 1'b0;
    unique case (phase)
      PH_SETTLE: begin
        sck_reg_next    = 1'b0;
        tick_count_next = half_done ? '0 : tick_inc;
        if (half_done) begin
          phase_next = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!dout_level) begin
          sck_reg_next    = 1'b1;
          tick_count_next = '0;
          bit_count_next  = '0;
          shift_data_next = '0;
          phase_next      = PH_HIGH;
        end
      end
      PH_HIGH: begin
        tick_count_next = half_done ? '0 : tick_inc;
        if (half_done) begin
          sck_reg_next    = 1'b0;
          shift_data_next = {shift_data[DATA_BITS-2:0], dout_level};
          bit_count_next  = bit_count + BIT_W'(1);
          phase_next      = PH_LOW;
        end
      end
      PH_LOW: begin
        tick_count_next = half_done ? '0 : tick_inc;
        if (half_done) begin
          sck_reg_next = 1'b1;
          phase_next   = (bit_count >= BIT_W'(DATA_BITS)) ? PH_GAIN : PH_HIGH;
        end
      end
      PH_GAIN: begin
        tick_count_next = half_done ? '0 : tick_inc;
        if (half_done) begin
          sck_reg_next  = 1'b0;
          last_raw_next = shift_data ^ RAW_FLIP;
          if (pend_eff) begin
            tare_value_next   = shift_data ^ RAW_FLIP;
            tare_pending_next = 1'b0;
          end
          complete   = 1'b1;
          phase_next = PH_SETTLE;
        end
      end
      default: begin
        sck_reg_next    = 1'b0;
        tick_count_next = '0;
        phase_next      = PH_SETTLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SETTLE;
      tick_count   <= '0;
      bit_count    <= '0;
      shift_data   <= '0;
      tare_value   <= '0;
      last_raw     <= '0;
      tare_pending <= 1'b0;
      sck_reg      <= 1'b0;
      captured     <= 1'b0;
    end else begin
      captured <= step & complete;
      if (step) begin
        phase        <= phase_next;
        tick_count   <= tick_count_next;
        bit_count    <= bit_count_next;
        shift_data   <= shift_data_next;
        tare_value   <= tare_value_next;
        last_raw     <= last_raw_next;
        tare_pending <= tare_pending_next;
        sck_reg      <= sck_reg_next;
      end
    end
  end

  assign status.sck      = sck_reg;
  assign status.sck_next = sck_reg_next;
  assign status.complete = complete;
  assign status.captured = captured;
  assign status.raw      = last_raw;
  assign status.tare     = tare_value;

endmodule

// ===== rtl/lcsr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsr_div
// Net weight: restoring divide of (raw - tare) << (FRAC_BITS + 1) by gap_x2,
// one quotient bit per cycle, zero if raw <= tare, saturating to weight width.
// ----------------------------------------------------------------------------
module lcsr_div import lcsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DATA_BITS-1:0] raw,
  input  logic [DATA_BITS-1:0] tare,
  input  logic [GAP_W-1:0]     gap_x2,
  output lcsr_div_t            status
);

  div_state_t          state;
  logic [CNT_W-1:0]    cnt;
  logic [QUO_W-1:0]    acc;    // dividend shifts out, quotient shifts in
  logic [GAP_W-1:0]    rem;
  logic [WEIGHT_W-1:0] last_weight;
  logic                done;
  logic [DATA_BITS:0]  diff;
  logic [GAP_W:0]      trial;
  logic [GAP_W:0]      trial_sub;
  logic                fits;

  assign diff      = {1'b0, raw} - {1'b0, tare};
  assign trial     = {rem, acc[QUO_W-1]};
  assign trial_sub = trial - {1'b0, gap_x2};
  assign fits      = (trial >= {1'b0, gap_x2});

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= DV_IDLE;
      cnt         <= '0;
      done        <= 1'b0;
      last_weight <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        DV_IDLE: begin
          if (start) begin
            rem <= '0;
            cnt <= CNT_W'(QUO_W);
            if (diff[DATA_BITS] || (diff == '0)) begin
              acc   <= '0;
              state <= DV_FIN;
            end else if (gap_x2 == '0) begin
              acc   <= '1;
              state <= DV_FIN;
            end else begin
              acc   <= QUO_W'({diff[DATA_BITS-1:0], {(FRAC_BITS+1){1'b0}}});
              state <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          acc <= {acc[QUO_W-2:0], fits};
          rem <= fits ? trial_sub[GAP_W-1:0] : trial[GAP_W-1:0];
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= DV_FIN;
          end
        end
        DV_FIN: begin
          last_weight <= (|acc[QUO_W-1:WEIGHT_W]) ? '1 : acc[WEIGHT_W-1:0];
          done        <= 1'b1;
          state       <= DV_IDLE;
        end
        default: begin
          state <= DV_IDLE;
        end
      endcase
    end
  end

  assign status.done   = done;
  assign status.weight = last_weight;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the load cell reader tick by tick against an in-bench copy of its
// behaviour: serial clock level, sample flag, raw code and net weight of every
// transaction, under random idling on both channels and several register
// settings.
// ----------------------------------------------------------------------------
module testbench;
  import lcsr_pkg::*;

  localparam int LIMIT_CYCLES   = 4_000_000;
  localparam int DRAIN_CYCLES   = 48;
  localparam int RANDOM_SAMPLES = 1;
  localparam int POWER_ON_TICKS = 172;

  typedef struct packed {
    logic                 sck_level;
    logic                 sample_valid;
    logic [DATA_BITS-1:0] raw_code;
    logic [WEIGHT_W-1:0]  weight_q8;
  } pin_result_t;

  typedef enum logic [1:0] {TARE_NONE, TARE_EARLY, TARE_FINAL} tare_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lcsr_in_if  tick_bus ();
  lcsr_out_if result_bus ();

  load_cell_serial_reader_tare_scale_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_bus),
    .result    (result_bus)
  );

  // expected reader state
  logic [HALF_W-1:0]    half_ticks    = HALF_RESET;
  logic [GAP_W-1:0]     gap_divisor   = GAP_RESET;
  phase_t               rd_phase      = PH_SETTLE;
  logic [HALF_W-1:0]    rd_ticks      = '0;
  logic [BIT_W-1:0]     rd_bits       = '0;
  logic [DATA_BITS-1:0] rd_shift      = '0;
  logic [DATA_BITS-1:0] rd_tare       = '0;
  logic [DATA_BITS-1:0] rd_raw        = '0;
  logic                 rd_tare_armed = 1'b0;
  logic                 rd_sck        = 1'b0;
  logic [WEIGHT_W-1:0]  rd_weight     = '0;

  pin_result_t pin_results_due[$];
  int          samples_taken = 0;
  int          failures      = 0;
  bit          tx_calm       = 1'b0;
  bit          rx_calm       = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int half_limit();
    return (half_ticks == '0) ? 1 : int'(half_ticks);
  endfunction

  function automatic logic edge_due();
    return (int'(rd_ticks) + 1 >= half_limit());
  endfunction

  function automatic logic half_elapsed();
    logic hit;
    hit = edge_due();
    rd_ticks = hit ? '0 : rd_ticks + 1'b1;
    return hit;
  endfunction

  function automatic logic [WEIGHT_W-1:0] net_weight(input logic [DATA_BITS-1:0] raw,
                                                     input logic [DATA_BITS-1:0] tare);
    logic [63:0] num;
    logic [63:0] quo;
    if (raw <= tare) return '0;
    if (gap_divisor == '0) return '1;
    num = 64'(raw - tare) << (FRAC_BITS + 1);
    quo = num / 64'(gap_divisor);
    if (quo > 64'hFFFF_FFFF) return '1;
    return quo[WEIGHT_W-1:0];
  endfunction

  function automatic pin_result_t advance_reader(input logic d, input logic t);
    pin_result_t r;
    logic        fresh;
    fresh = 1'b0;
    if (t) rd_tare_armed = 1'b1;
    case (rd_phase)
      PH_SETTLE: begin
        rd_sck = 1'b0;
        if (half_elapsed()) rd_phase = PH_WAIT;
      end
      PH_WAIT: begin
        if (!d) begin
          rd_sck   = 1'b1;
          rd_ticks = '0;
          rd_bits  = '0;
          rd_shift = '0;
          rd_phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (half_elapsed()) begin
          rd_sck   = 1'b0;
          rd_shift = {rd_shift[DATA_BITS-2:0], d};
          rd_bits  = rd_bits + 1'b1;
          rd_phase = PH_LOW;
        end
      end
      PH_LOW: begin
        if (half_elapsed()) begin
          rd_sck   = 1'b1;
          rd_phase = (rd_bits >= DATA_BITS) ? PH_GAIN : PH_HIGH;
        end
      end
      PH_GAIN: begin
        if (half_elapsed()) begin
          rd_sck = 1'b0;
          rd_raw = rd_shift ^ RAW_FLIP;
          if (rd_tare_armed) begin
            rd_tare       = rd_raw;
            rd_tare_armed = 1'b0;
          end
          rd_weight = net_weight(rd_raw, rd_tare);
          fresh     = 1'b1;
          rd_ticks  = '0;
          rd_phase  = PH_SETTLE;
        end
      end
      default: begin
        rd_sck   = 1'b0;
        rd_ticks = '0;
        rd_phase = PH_SETTLE;
      end
    endcase
    if (fresh) samples_taken++;
    r.sck_level    = rd_sck;
    r.sample_valid = fresh;
    r.raw_code     = rd_raw;
    r.weight_q8    = rd_weight;
    return r;
  endfunction

  function automatic logic [DATA_BITS-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return RAW_FLIP;
      3: return ~RAW_FLIP;
      default: return DATA_BITS'($urandom);
    endcase
  endfunction

  task automatic send_tick(input logic d, input logic t, output logic completed);
    int          gap;
    pin_result_t due;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_bus.valid        <= 1'b1;
    tick_bus.dout_level   <= d;
    tick_bus.tare_request <= t;
    do @(posedge clk); while (!tick_bus.ready);
    due = advance_reader(d, t);
    pin_results_due.push_back(due);
    completed = due.sample_valid;
  endtask

  // hold the input off until every transaction has come back
  task automatic await_outputs();
    tick_bus.valid <= 1'b0;
    do @(posedge clk); while (pin_results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    await_outputs();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HALF_PERIOD) half_ticks = val[HALF_W-1:0];
    else gap_divisor = val[GAP_W-1:0];
  endtask

  task automatic send_noise(input int n, input logic allow_tare);
    logic completed;
    repeat (n) begin
      send_tick(1'($urandom_range(0, 1)), allow_tare && ($urandom_range(0, 7) == 0),
                completed);
    end
  endtask

  // drives one conversion frame: data pin set to the word on falling edge
  // ticks, random elsewhere
  task automatic run_sample(input logic [DATA_BITS-1:0] word, input tare_mode_t tmode);
    logic d;
    logic t;
    logic completed;
    logic first;
    completed = 1'b0;
    first     = 1'b1;
    while (!completed) begin
      d = 1'($urandom_range(0, 1));
      case (rd_phase)
        PH_WAIT: d = ($urandom_range(0, 2) == 0);
        PH_HIGH: if (edge_due()) d = word[DATA_BITS - 1 - int'(rd_bits)];
        default: begin
        end
      endcase
      t = (tmode == TARE_EARLY && first) ||
          (tmode == TARE_FINAL && rd_phase == PH_GAIN && edge_due());
      send_tick(d, t, completed);
      first = 1'b0;
    end
  endtask

  // data pin held low from reset: the first pulse starts once the settle
  // wait at the reset half period has run out
  task automatic test_power_on_config();
    logic completed;
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (POWER_ON_TICKS) send_tick(1'b0, 1'b0, completed);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_half_period();
    write_reg(REG_HALF_PERIOD, CFG_W'(16'hFFFF));
    send_noise(8, 1'b0);
    write_reg(REG_HALF_PERIOD, '0);
    run_sample(24'h000000, TARE_NONE);
  endtask

  task automatic test_divisor();
    write_reg(REG_GAP_X2, '0);
    run_sample(24'h7FFFFF, TARE_NONE);
    write_reg(REG_GAP_X2, CFG_W'(1));
    run_sample(24'h7FFFFF, TARE_NONE);
  endtask

  task automatic test_tare();
    write_reg(REG_GAP_X2, CFG_W'(21001));
    run_sample(24'h923456, TARE_EARLY);
    run_sample(24'h912345, TARE_NONE);
    run_sample(24'h934567, TARE_FINAL);
  endtask

  task automatic test_random();
    int         goal;
    int         pick;
    tare_mode_t tmode;
    goal = samples_taken + RANDOM_SAMPLES;
    while (samples_taken < goal) begin
      if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        write_reg(REG_HALF_PERIOD, CFG_W'(($urandom_range(0, 9) == 0) ?
                  $urandom_range(4, 6) : $urandom_range(0, 3)));
      end else if (pick == 1) begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_GAP_X2, CFG_W'($urandom_range(0, 4)));
          1: write_reg(REG_GAP_X2, CFG_W'($urandom_range(0, 24'hFFFFFF)));
          default: write_reg(REG_GAP_X2, CFG_W'($urandom_range(2, 40000)));
        endcase
      end else if (pick == 2) begin
        send_noise($urandom_range(1, 30), 1'b1);
      end else if (pick == 3) begin
        await_outputs();
      end else begin
        case ($urandom_range(0, 9))
          0: tmode = TARE_EARLY;
          1: tmode = TARE_FINAL;
          default: tmode = TARE_NONE;
        endcase
        run_sample(random_word(), tmode);
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // result side: random stalls, every transaction checked in order
  initial begin
    int          stall;
    pin_result_t want;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      if (pin_results_due.size() == 0) begin
        $error("result transaction with nothing expected");
        failures++;
      end else begin
        want = pin_results_due.pop_front();
        if (result_bus.sck_level !== want.sck_level) begin
          $error("sck_level: expected %0d, got %0d", want.sck_level, result_bus.sck_level);
          failures++;
        end
        if (result_bus.sample_valid !== want.sample_valid) begin
          $error("sample_valid: expected %0d, got %0d",
                 want.sample_valid, result_bus.sample_valid);
          failures++;
        end
        if (result_bus.raw_code !== want.raw_code) begin
          $error("raw_code: expected %h, got %h", want.raw_code, result_bus.raw_code);
          failures++;
        end
        if (result_bus.weight_q8 !== want.weight_q8) begin
          $error("weight_q8: expected %h, got %h", want.weight_q8, result_bus.weight_q8);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_HALF_PERIOD;
    cfg_data              <= '0;
    tick_bus.valid        <= 1'b0;
    tick_bus.dout_level   <= 1'b1;
    tick_bus.tare_request <= 1'b0;
    result_bus.ready      <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_on_config();
    test_half_period();
    test_divisor();
    test_tare();
    test_random();
    await_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lcsr_pkg.sv
rtl/lcsr_if.sv
rtl/lcsr_seq.sv
rtl/lcsr_div.sv
rtl/load_cell_serial_reader_tare_scale_core.sv
sim/testbench.sv
